FILE: src/life_grid_generation_step_defines.svh
// ----------------------------------------------------------------------------
// Life grid assertion macros
// Shared property macros for the life grid generation step block.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_STEP_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lgs_pkg.sv
// ----------------------------------------------------------------------------
// Life grid package
// Types and fixed constants shared by the life grid generation step modules.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_GEN,
        ST_RESP
    } t_state;

    // Request kinds carried on tuser.
    typedef enum logic [1:0] {
        MODE_SET  = 2'd0,
        MODE_READ = 2'd1,
        MODE_STEP = 2'd2
    } t_mode;

    localparam int REG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int MODE_W     = 2;
    localparam int COORD_W    = 6;
    localparam int COUNT_W    = 13;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int NBR_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam logic [REG_W-1:0] SIZE_RESET = 7'd64;

    // B3/S23 neighbor counts.
    localparam logic [NBR_W-1:0] BIRTH_N   = 4'd3;
    localparam logic [NBR_W-1:0] SURVIVE_N = 4'd2;

    // Input tdata layout.
    localparam int IN_ROW_LSB = 0;
    localparam int IN_COL_LSB = 6;
    localparam int IN_VAL_BIT = 12;

endpackage

FILE: src/lgs_row_unit.sv
// ----------------------------------------------------------------------------
// Life grid row unit
// Applies the B3/S23 rule to one full row from a three-row window.
// ----------------------------------------------------------------------------
module lgs_row_unit #(
    parameter int MAX_COLS = 64
) (
    input  logic [MAX_COLS-1:0] i_prev,
    input  logic [MAX_COLS-1:0] i_cur,
    input  logic [MAX_COLS-1:0] i_next,
    input  logic [MAX_COLS-1:0] i_mask,
    output logic [MAX_COLS-1:0] o_new_row,
    output logic [MAX_COLS-1:0] o_changed
);
    import lgs_pkg::*;

    logic [MAX_COLS+1:0] w_p;
    logic [MAX_COLS+1:0] w_c;
    logic [MAX_COLS+1:0] w_n;
    logic [NBR_W-1:0]    w_cnt [MAX_COLS];
    logic [MAX_COLS-1:0] w_nxt;

    // Columns outside the active area read as dead, as do both outer edges.
    assign w_p = {1'b0, i_prev & i_mask, 1'b0};
    assign w_c = {1'b0, i_cur  & i_mask, 1'b0};
    assign w_n = {1'b0, i_next & i_mask, 1'b0};

    always_comb begin
        for (int i = 0; i < MAX_COLS; i++) begin
            w_cnt[i] = NBR_W'(w_p[i]) + NBR_W'(w_p[i+1]) + NBR_W'(w_p[i+2])
                     + NBR_W'(w_c[i]) + NBR_W'(w_c[i+2])
                     + NBR_W'(w_n[i]) + NBR_W'(w_n[i+1]) + NBR_W'(w_n[i+2]);
            w_nxt[i] = (w_cnt[i] == BIRTH_N) || (w_c[i+1] && (w_cnt[i] == SURVIVE_N));
            o_new_row[i] = i_mask[i] ? w_nxt[i] : i_cur[i];
            o_changed[i] = i_mask[i] & (w_nxt[i] ^ w_c[i+1]);
        end
    end

endmodule

FILE: src/life_grid_generation_step.sv
// ----------------------------------------------------------------------------
// Life grid generation step
// Bounded B3/S23 grid with set, read and one-generation step requests.
// ----------------------------------------------------------------------------
// Usage: requests enter on the s_axis channel (tuser = kind, tdata = row,
// column and value) and each gives exactly one result on m_axis. The size in
// use comes from two registers, written through i_cfg_we/i_cfg_idx/i_cfg_data
// by the user only while the block is idle; the block does not enforce this.
// A set or read fetches its row from the grid memory on acceptance, writes or
// reads the cell in ST_ACCESS and loads the output register in ST_RESP; a
// coordinate out of range goes straight to ST_RESP. A step sweeps the grid
// memory one row per cycle through the shared row unit, a rate set by the
// single memory read port, and ends with the two-stage changed-cell count.
// The block takes one request at a time; s_axis_tready is high only between
// requests. A finished result waits in the output register, and the next
// request is accepted meanwhile; its result is held until the receiver takes
// the previous one.
// After reset the grid memory is cleared one row per cycle, all MAX_ROWS rows,
// with s_axis_tready low; the registers return to 64 x 64.
// ----------------------------------------------------------------------------
`include "life_grid_generation_step_defines.svh"

module life_grid_generation_step #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lgs_pkg::REG_W-1:0]            i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [5:0] row, [11:6] col, [12] cell_value, [15:13] zero
    input  logic [lgs_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [1:0] mode
    input  logic [lgs_pkg::MODE_W-1:0]           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] cell_alive, [13:1] changed_count, [14] out_of_range, [15] zero
    output logic [lgs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import lgs_pkg::*;

    localparam int AW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_ROWS + 4);
    localparam int NRW = $clog2(MAX_ROWS + 1);
    localparam int RCW = (NRW > REG_W) ? NRW : REG_W;
    localparam int CBW = $clog2(MAX_COLS);
    localparam int NG  = (MAX_COLS + 7) / 8;
    localparam int GTW = $clog2(MAX_COLS + 1);

    // Registers and state.
    t_state              r_state, n_state;
    logic [REG_W-1:0]    r_rows, r_cols;
    logic [CW-1:0]       r_cnt;
    logic [MODE_W-1:0]   r_mode;
    logic [COORD_W-1:0]  r_row, r_col;
    logic                r_val;
    logic                r_alive, r_oor;
    logic [COUNT_W-1:0]  r_count;
    logic [MAX_COLS-1:0] r_w0, r_w1;
    logic [MAX_COLS-1:0] r_chg_vec;
    logic                r_chg_vld;
    logic [3:0]          r_grp [NG];
    logic                r_grp_vld;
    logic                r_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;
    logic [MAX_COLS-1:0] r_grid [MAX_ROWS];
    logic [MAX_COLS-1:0] r_rdata;

    // Combinational signals.
    logic                w_accept;
    logic [MODE_W-1:0]   w_in_mode;
    logic [COORD_W-1:0]  w_in_row, w_in_col;
    logic                w_in_val, w_in_rw, w_in_oor;
    logic [RCW-1:0]      w_rows_ext;
    logic [NRW-1:0]      w_nr;
    logic [REG_W-1:0]    w_nc;
    logic [MAX_COLS-1:0] w_mask;
    logic [CW-1:0]       w_nr_c, w_gen_row;
    logic [CBW-1:0]      w_col_idx;
    logic [MAX_COLS-1:0] w_bit;
    logic                w_mem_we, w_mem_re;
    logic [AW-1:0]       w_wr_addr, w_rd_addr;
    logic [MAX_COLS-1:0] w_wr_data;
    logic                w_shift, w_compute, w_load_out;
    logic [MAX_COLS-1:0] w_incoming, w_new_row, w_changed;
    logic [NG*8-1:0]     w_chg_pad;
    logic [3:0]          w_grp [NG];
    logic [GTW-1:0]      w_grp_total;

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_in_mode = s_axis_tuser;
    assign w_in_row  = s_axis_tdata[IN_ROW_LSB +: COORD_W];
    assign w_in_col  = s_axis_tdata[IN_COL_LSB +: COORD_W];
    assign w_in_val  = s_axis_tdata[IN_VAL_BIT];
    assign w_in_rw   = (w_in_mode == MODE_SET) || (w_in_mode == MODE_READ);

    // Sizes in use, clamped to 1..maximum.
    always_comb begin
        w_rows_ext = RCW'(r_rows);
        if (w_rows_ext == '0) begin
            w_nr = NRW'(1);
        end else if (w_rows_ext > RCW'(MAX_ROWS)) begin
            w_nr = NRW'(MAX_ROWS);
        end else begin
            w_nr = NRW'(w_rows_ext);
        end
        if (r_cols == '0) begin
            w_nc = REG_W'(1);
        end else if (r_cols > REG_W'(MAX_COLS)) begin
            w_nc = REG_W'(MAX_COLS);
        end else begin
            w_nc = r_cols;
        end
        for (int i = 0; i < MAX_COLS; i++) begin
            w_mask[i] = REG_W'(i) < w_nc;
        end
    end

    assign w_in_oor  = (RCW'(w_in_row) >= RCW'(w_nr)) || (REG_W'(w_in_col) >= w_nc);
    assign w_nr_c    = CW'(w_nr);
    assign w_gen_row = r_cnt - CW'(2);
    assign w_col_idx = CBW'(r_col);
    assign w_bit     = MAX_COLS'(1) << w_col_idx;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_cnt == CW'(MAX_ROWS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_in_mode inside {MODE_SET, MODE_READ}) begin
                        n_state = w_in_oor ? ST_RESP : ST_ACCESS;
                    end else if (w_in_mode == MODE_STEP) begin
                        n_state = ST_GEN;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_ACCESS: n_state = ST_RESP;
            ST_GEN: begin
                if (r_cnt == w_nr_c + CW'(3)) n_state = ST_RESP;
            end
            ST_RESP: begin
                if (w_load_out) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;
        w_wr_addr  = r_cnt[AW-1:0];
        w_rd_addr  = r_cnt[AW-1:0];
        w_wr_data  = '0;
        w_shift    = 1'b0;
        w_compute  = 1'b0;
        w_load_out = 1'b0;
        w_incoming = '0;
        case (r_state)
            ST_CLEAR: begin
                w_mem_we = 1'b1;
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_rd_addr = AW'(w_in_row);
                w_mem_re  = w_accept && w_in_rw && !w_in_oor;
            end
            ST_ACCESS: begin
                w_wr_addr = AW'(r_row);
                w_mem_we  = (r_mode == MODE_SET);
                w_wr_data = r_val ? (r_rdata | w_bit) : (r_rdata & ~w_bit);
            end
            ST_GEN: begin
                // Read row k while row k-2 is judged on rows k-3, k-2 and k-1.
                w_mem_re  = r_cnt < w_nr_c;
                w_shift   = (r_cnt >= CW'(1)) && (r_cnt <= w_nr_c + CW'(1));
                w_compute = (r_cnt >= CW'(2)) && (r_cnt <= w_nr_c + CW'(1));
                if (r_cnt <= w_nr_c) w_incoming = r_rdata;
                w_mem_we  = w_compute;
                w_wr_addr = w_gen_row[AW-1:0];
                w_wr_data = w_new_row;
            end
            ST_RESP: begin
                w_load_out = !r_m_tvalid || m_axis_tready;
            end
            default: ;
        endcase
    end

    lgs_row_unit #(
        .MAX_COLS (MAX_COLS)
    ) u_row_unit (
        .i_prev    (r_w0),
        .i_cur     (r_w1),
        .i_next    (w_incoming),
        .i_mask    (w_mask),
        .o_new_row (w_new_row),
        .o_changed (w_changed)
    );

    // Changed-cell count: groups of eight, then the group sums.
    always_comb begin
        w_chg_pad = '0;
        w_chg_pad[MAX_COLS-1:0] = r_chg_vec;
        for (int g = 0; g < NG; g++) begin
            w_grp[g] = '0;
            for (int j = 0; j < 8; j++) begin
                w_grp[g] = w_grp[g] + 4'(w_chg_pad[g*8+j]);
            end
        end
        w_grp_total = '0;
        for (int g = 0; g < NG; g++) begin
            w_grp_total = w_grp_total + GTW'(r_grp[g]);
        end
    end

    // Grid memory.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_grid[w_wr_addr] <= w_wr_data;
        if (w_mem_re) r_rdata <= r_grid[w_rd_addr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cnt      <= '0;
            r_rows     <= SIZE_RESET;
            r_cols     <= SIZE_RESET;
            r_chg_vld  <= 1'b0;
            r_grp_vld  <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chg_vld <= w_compute;
            r_grp_vld <= r_chg_vld;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROWS: r_rows <= i_cfg_data;
                    CFG_COLS: r_cols <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == ST_CLEAR || r_state == ST_GEN) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (w_load_out) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= w_in_mode;
            r_row   <= w_in_row;
            r_col   <= w_in_col;
            r_val   <= w_in_val;
            r_alive <= 1'b0;
            r_oor   <= w_in_rw && w_in_oor;
            r_count <= '0;
            r_w0    <= '0;
            r_w1    <= '0;
        end else begin
            if (r_state == ST_ACCESS) begin
                r_alive <= (r_mode == MODE_SET) ? r_val : r_rdata[w_col_idx];
            end
            if (w_shift) begin
                r_w0 <= r_w1;
                r_w1 <= w_incoming;
            end
            if (r_grp_vld) begin
                r_count <= r_count + COUNT_W'(w_grp_total);
            end
        end
        if (w_compute) r_chg_vec <= w_changed;
        if (r_chg_vld) begin
            for (int g = 0; g < NG; g++) begin
                r_grp[g] <= w_grp[g];
            end
        end
        if (w_load_out) r_m_tdata <= {1'b0, r_oor, r_count, r_alive};
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    `LGS_ASSERT_IMPLY(a_gen_write_in_rows, i_clk, i_rst_n,
        (r_state == ST_GEN) && w_mem_we, w_gen_row < w_nr_c, "step wrote past active rows")
    `LGS_ASSERT_NEXT(a_step_starts_sweep, i_clk, i_rst_n,
        w_accept && (w_in_mode == MODE_STEP), (r_state == ST_GEN) && (r_cnt == '0),
        "step request did not start a sweep")
    `LGS_ASSERT_IMPLY(a_oor_result_clean, i_clk, i_rst_n,
        r_m_tvalid && r_m_tdata[14], (r_m_tdata[0] == 1'b0) && (r_m_tdata[13:1] == '0),
        "out-of-range result carries data")

endmodule

FILE: dv/life_grid_generation_step_test.sv
// ----------------------------------------------------------------------------
// Life grid generation step testbench
// Drives set, read and step requests into the bounded B3/S23 grid under many
// grid sizes, with random idle cycles on both streams. A scoreboard keeps its
// own copy of the grid and the size registers, predicts the result of every
// accepted request and checks each returned result field by field.
// ----------------------------------------------------------------------------
module life_grid_generation_step_test;
    import lgs_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int MAX_GAP       = 13;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 80;
    localparam int N_PHASES      = 14;
    localparam int PHASE_QUOTA   = 98;

    typedef struct packed {
        logic               alive;
        logic [COUNT_W-1:0] changed;
        logic               oor;
    } t_life_result;

    // Keeps a private copy of the grid and sizes and queues the result that
    // each accepted request must produce.
    class grid_tracker;
        logic [63:0]      cells [64];
        logic [REG_W-1:0] rows_reg;
        logic [REG_W-1:0] cols_reg;
        t_life_result     awaited [$];
        int               errors;
        int               checked;
        int               n_set;
        int               n_read;
        int               n_step;
        int               n_oor;
        int               n_unused;
        longint           flips;

        function new();
            foreach (cells[r]) cells[r] = '0;
            rows_reg = SIZE_RESET;
            cols_reg = SIZE_RESET;
            errors   = 0;
            checked  = 0;
            n_set    = 0;
            n_read   = 0;
            n_step   = 0;
            n_oor    = 0;
            n_unused = 0;
            flips    = 0;
        endfunction

        // A size of zero acts as one, anything past the grid acts as the grid.
        function int clamp(logic [REG_W-1:0] v);
            if (v == 0) return 1;
            if (v > 64) return 64;
            return int'(v);
        endfunction

        function int rows_active();
            return clamp(rows_reg);
        endfunction

        function int cols_active();
            return clamp(cols_reg);
        endfunction

        function void write_size(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] v);
            if (idx == CFG_ROWS) rows_reg = v;
            else cols_reg = v;
        endfunction

        function bit live_at(int r, int c, int nr, int nc);
            if (r < 0 || c < 0 || r >= nr || c >= nc) return 1'b0;
            return cells[r][c];
        endfunction

        // Judges every active cell on the old grid, then commits all of them.
        // Cells outside the active area keep their stored values.
        function int next_generation();
            logic [63:0] nxt [64];
            int          nr;
            int          nc;
            int          n;
            int          cnt;
            bit          alive;
            bit          born;
            nr  = rows_active();
            nc  = cols_active();
            cnt = 0;
            nxt = cells;
            for (int r = 0; r < nr; r++) begin
                for (int c = 0; c < nc; c++) begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++)
                        for (int dc = -1; dc <= 1; dc++)
                            if (dr != 0 || dc != 0) n += live_at(r + dr, c + dc, nr, nc);
                    alive = cells[r][c];
                    if (alive) born = (n == SURVIVE_N) || (n == BIRTH_N);
                    else born = (n == BIRTH_N);
                    if (born != alive) cnt++;
                    nxt[r][c] = born;
                end
            end
            cells = nxt;
            return cnt;
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [COORD_W-1:0] row,
                                   logic [COORD_W-1:0] col, logic val);
            t_life_result res;
            res = '0;
            case (mode)
                MODE_SET, MODE_READ: begin
                    if (row >= rows_active() || col >= cols_active()) begin
                        res.oor = 1'b1;
                        n_oor++;
                    end else begin
                        if (mode == MODE_SET) cells[row][col] = val;
                        res.alive = cells[row][col];
                    end
                    if (mode == MODE_SET) n_set++;
                    else n_read++;
                end
                MODE_STEP: begin
                    res.changed = COUNT_W'(next_generation());
                    flips += res.changed;
                    n_step++;
                end
                default: n_unused++;
            endcase
            awaited.insert(awaited.size(), res);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            t_life_result       want;
            logic               alive;
            logic [COUNT_W-1:0] changed;
            logic               oor;
            alive   = data[0];
            changed = data[COUNT_W:1];
            oor     = data[COUNT_W+1];
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual tdata %h", $time, data);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (alive !== want.alive) begin
                errors++;
                $display("%0t: cell_alive mismatch, expected %0d, actual %0d",
                         $time, want.alive, alive);
            end
            if (changed !== want.changed) begin
                errors++;
                $display("%0t: changed_count mismatch, expected %0d, actual %0d",
                         $time, want.changed, changed);
            end
            if (oor !== want.oor) begin
                errors++;
                $display("%0t: out_of_range mismatch, expected %0d, actual %0d",
                         $time, want.oor, oor);
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [REG_W-1:0]        i_cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic [MODE_W-1:0]       s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    grid_tracker sb;
    int          tx_gap     = 0;
    int          tx_burst   = 0;
    int          rx_burst   = 0;
    int          sent       = 0;
    int          n_settings = 0;
    int          quiet      = 0;

    life_grid_generation_step DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Idle cycles before the next handshake, with occasional runs of none.
    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Valid stays high into the next request when no gap was drawn.
    task automatic send_request(logic [MODE_W-1:0] mode, logic [COORD_W-1:0] row,
                                logic [COORD_W-1:0] col, logic val);
        repeat (tx_gap) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, val, col, row};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        sb.note_request(mode, row, col, val);
        sent++;
        tx_gap = draw_gap(tx_burst);
        if (tx_gap != 0) s_axis_tvalid <= 1'b0;
    endtask

    task automatic hold_sender();
        if (tx_gap == 0) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 1;
        end
    endtask

    task automatic write_sizes(logic [REG_W-1:0] rows, logic [REG_W-1:0] cols);
        hold_sender();
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        sb.write_size(CFG_ROWS, rows);
        i_cfg_idx  <= CFG_COLS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        sb.write_size(CFG_COLS, cols);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Out-of-range coordinates, the unused mode, or a plain read.
    task automatic send_noise(int nr, int nc);
        case ($urandom_range(0, 3))
            0: send_request(MODE_SET, 6'($urandom), 6'($urandom), 1'($urandom));
            1: send_request(MODE_READ, 6'($urandom), 6'($urandom), 1'($urandom));
            2: send_request(MODE_UNUSED, 6'($urandom), 6'($urandom), 1'($urandom));
            default: send_request(MODE_READ, 6'($urandom_range(0, nr - 1)),
                                  6'($urandom_range(0, nc - 1)), 1'b0);
        endcase
    endtask

    // Rounds of seeding a window with live cells, stepping it and reading it
    // back, salted with noise requests.
    task automatic run_phase(logic [REG_W-1:0] rows, logic [REG_W-1:0] cols, int quota);
        int nr;
        int nc;
        int wr;
        int wc;
        int r0;
        int c0;
        int stop;
        write_sizes(rows, cols);
        nr   = sb.rows_active();
        nc   = sb.cols_active();
        stop = sent + quota;
        while (sent < stop) begin
            wr = ($urandom_range(0, 3) == 0 || nr < 8) ? nr : 8;
            wc = ($urandom_range(0, 3) == 0 || nc < 8) ? nc : 8;
            r0 = $urandom_range(0, nr - wr);
            c0 = $urandom_range(0, nc - wc);
            repeat ($urandom_range(3, 14)) begin
                if ($urandom_range(0, 6) == 0) send_noise(nr, nc);
                else send_request(MODE_SET, 6'(r0 + $urandom_range(0, wr - 1)),
                                  6'(c0 + $urandom_range(0, wc - 1)),
                                  $urandom_range(0, 9) != 0);
            end
            repeat ($urandom_range(1, 4))
                send_request(MODE_STEP, 6'($urandom), 6'($urandom), 1'($urandom));
            repeat ($urandom_range(1, 4))
                send_request(MODE_READ, 6'(r0 + $urandom_range(0, wr - 1)),
                             6'(c0 + $urandom_range(0, wc - 1)), 1'($urandom));
        end
    endtask

    initial begin
        logic [REG_W-1:0] phase_rows [N_PHASES];
        logic [REG_W-1:0] phase_cols [N_PHASES];
        phase_rows = '{7'd0, 7'd127, 7'd8, 7'd1, 7'd64, 7'd3, 7'd100,
                       7'd16, 7'd12, 7'd64, 7'd6, 7'd127, 7'd2, 7'd24};
        phase_cols = '{7'd127, 7'd0, 7'd8, 7'd1, 7'd64, 7'd5, 7'd20,
                       7'd64, 7'd12, 7'd3, 7'd10, 7'd127, 7'd40, 7'd24};
        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_ROWS;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_SET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full 64 x 64 grid: the four corners must all die, since edges do
        // not wrap. Then a blinker oscillates twice and is broken up.
        send_request(MODE_READ, 6'd0, 6'd0, 1'b0);
        send_request(MODE_SET, 6'd0, 6'd0, 1'b1);
        send_request(MODE_SET, 6'd63, 6'd63, 1'b1);
        send_request(MODE_SET, 6'd0, 6'd63, 1'b1);
        send_request(MODE_SET, 6'd63, 6'd0, 1'b1);
        send_request(MODE_READ, 6'd63, 6'd63, 1'b0);
        send_request(MODE_STEP, 6'd0, 6'd0, 1'b0);
        send_request(MODE_READ, 6'd0, 6'd0, 1'b0);
        send_request(MODE_SET, 6'd10, 6'd20, 1'b1);
        send_request(MODE_SET, 6'd10, 6'd21, 1'b1);
        send_request(MODE_SET, 6'd10, 6'd22, 1'b1);
        send_request(MODE_STEP, 6'd63, 6'd63, 1'b1);
        send_request(MODE_READ, 6'd9, 6'd21, 1'b0);
        send_request(MODE_STEP, 6'd0, 6'd0, 1'b0);
        send_request(MODE_SET, 6'd10, 6'd21, 1'b0);
        send_request(MODE_UNUSED, 6'd63, 6'd63, 1'b1);
        send_request(MODE_STEP, 6'd0, 6'd0, 1'b0);

        // Small grid: coordinates just past each edge are flagged.
        write_sizes(7'd5, 7'd7);
        send_request(MODE_SET, 6'd5, 6'd0, 1'b1);
        send_request(MODE_READ, 6'd0, 6'd7, 1'b0);
        send_request(MODE_SET, 6'd63, 6'd63, 1'b1);
        send_request(MODE_SET, 6'd4, 6'd6, 1'b1);
        send_request(MODE_READ, 6'd4, 6'd6, 1'b0);
        send_request(MODE_STEP, 6'd0, 6'd0, 1'b0);

        for (int p = 0; p < N_PHASES; p++) run_phase(phase_rows[p], phase_cols[p], PHASE_QUOTA);

        hold_sender();
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d requests: %0d sets, %0d reads, %0d steps with %0d cell flips,",
                 sent, sb.n_set, sb.n_read, sb.n_step, sb.flips);
        $display("%0d flagged out of range, %0d unused mode; %0d results checked over %0d sizes.",
                 sb.n_oor, sb.n_unused, sb.checked, n_settings + 1);
        if (sb.errors == 0)
            $display("life_grid_generation_step_test: done, clean");
        else
            $display("life_grid_generation_step_test: done, errors");
        $finish;
    end

    // Result side: random stalls before each result is taken.
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_gap(rx_burst);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            sb.check_result(m_axis_tdata);
        end
    end

    // Ends the run if neither stream moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
            $display("life_grid_generation_step_test: done, errors");
            $finish;
        end
    end

endmodule

FILE: files.f
+incdir+src
src/lgs_pkg.sv
src/lgs_row_unit.sv
src/life_grid_generation_step.sv
dv/life_grid_generation_step_test.sv
